// ===== hw/rtl/human_readable_size_scaler_core_defines.svh =====
// ----------------------------------------------------------------------------
// Size Scaler Assertion Macros
// Shared concurrent assertion forms used by the size scaler RTL.
// ----------------------------------------------------------------------------
`ifndef HUMAN_READABLE_SIZE_SCALER_CORE_DEFINES_SVH
`define HUMAN_READABLE_SIZE_SCALER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRSS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("size scaler check failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define HRSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("size scaler check failed in next cycle");

`endif

// ===== hw/rtl/hrss_pkg.sv =====
// ----------------------------------------------------------------------------
// Size Scaler Package
// Constants and controller/datapath interface types for the size scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrss_pkg;

    localparam int VALUE_W  = 64;
    localparam int WHOLE_W  = 11;
    localparam int HUND_W   = 7;
    localparam int PREFIX_W = 3;
    localparam int REM_W    = 10;
    localparam int DIGIT_W  = 16;
    localparam int PARTIAL_W = REM_W + DIGIT_W;

    localparam logic [WHOLE_W-1:0]  BIN_DIV      = 11'd1024;
    localparam logic [WHOLE_W-1:0]  DEC_DIV      = 11'd1000;
    localparam logic [REM_W-1:0]    BIN_REM_MASK = 10'h3ff;
    localparam logic [6:0]          HUNDRED      = 7'd100;
    localparam logic [HUND_W-1:0]   MAX_HUND     = 7'd99;
    localparam logic [PREFIX_W-1:0] MAX_PREFIX   = 3'd6;

    // ceil(2^36 / 1000): exact quotient for any partial dividend below 1000 * 2^16.
    localparam logic [26:0] DEC_RECIP     = 27'd68719477;
    localparam int          DEC_SHIFT     = 36;
    // floor(x * 205 / 2^11) equals floor(x / 10) for every x below 1000.
    localparam logic [7:0]  TENTH_RECIP   = 8'd205;
    localparam int          TENTH_SHIFT   = 11;

    localparam logic [1:0]  DIGIT_LAST    = 2'd3;

    typedef struct packed {
        logic load;
        logic bin_shift;
        logic dec_start;
        logic dec_mul;
        logic dec_sub;
        logic dec_last;
        logic out_load;
    } hrss_cmd_t;

    typedef struct packed {
        logic more;
        logic binary;
    } hrss_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hrss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Size Scaler Controller
// Sequences the divide steps and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "human_readable_size_scaler_core_defines.svh"

module hrss_ctrl
    import hrss_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire hrss_status_t status,
    output hrss_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_SUB,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] digit_reg, digit_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        digit_next   = digit_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.more) begin
                    if (status.binary) begin
                        cmd.bin_shift = 1'b1;
                    end else begin
                        cmd.dec_start = 1'b1;
                        digit_next    = '0;
                        state_next    = S_MUL;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MUL: begin
                cmd.dec_mul = 1'b1;
                state_next  = S_SUB;
            end
            S_SUB: begin
                cmd.dec_sub = 1'b1;
                if (digit_reg == DIGIT_LAST) begin
                    cmd.dec_last = 1'b1;
                    state_next   = S_CHECK;
                end else begin
                    digit_next = digit_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            digit_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            digit_reg   <= digit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // A result must never overwrite one that has not been taken.
    `HRSS_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    // Every multiply step is followed by its subtract step.
    `HRSS_ASSERT_NEXT(a_mul_then_sub, aclk, aresetn, cmd.dec_mul, cmd.dec_sub)
    // A decimal division always begins on the first digit.
    `HRSS_ASSERT_NEXT(a_start_digit, aclk, aresetn, cmd.dec_start, digit_reg == 2'd0)

endmodule

`default_nettype wire

// ===== hw/rtl/hrss_datapath.sv =====
// ----------------------------------------------------------------------------
// Size Scaler Datapath
// Holds the working value and performs shift or divide-by-1000 steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "human_readable_size_scaler_core_defines.svh"

module hrss_datapath
    import hrss_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [VALUE_W-1:0]   s_byte_count,
    input  wire logic                 s_binary_prefix,
    input  wire hrss_cmd_t            cmd,
    output hrss_status_t              status,
    output logic [WHOLE_W-1:0]        m_whole_part,
    output logic [HUND_W-1:0]         m_hundredths,
    output logic [PREFIX_W-1:0]       m_prefix_index
);

    logic [VALUE_W-1:0]   val_reg;
    logic                 binary_reg;
    logic [PREFIX_W-1:0]  idx_reg;
    logic                 divided_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     prem_reg;
    logic [PARTIAL_W-1:0] x_reg;
    logic [DIGIT_W-1:0]   q_reg;
    logic [WHOLE_W-1:0]   whole_reg;
    logic [HUND_W-1:0]    hund_reg;
    logic [PREFIX_W-1:0]  prefix_reg;

    logic [WHOLE_W-1:0]   divisor;
    logic [PARTIAL_W-1:0] partial;
    logic [52:0]          recip_prod;
    logic [PARTIAL_W-1:0] partial_rem;
    logic [16:0]          bin_hund_prod;
    logic [17:0]          dec_hund_prod;
    logic [HUND_W-1:0]    hund_value;

    assign divisor = binary_reg ? BIN_DIV : DEC_DIV;

    assign status.binary = binary_reg;
    assign status.more   = (val_reg > {{(VALUE_W-WHOLE_W){1'b0}}, divisor})
                           && (idx_reg < MAX_PREFIX);

    // Long division by 1000 takes the dividend 16 bits at a time, top first.
    assign partial     = {prem_reg, val_reg[VALUE_W-1 -: DIGIT_W]};
    assign recip_prod  = 53'(partial) * 53'(DEC_RECIP);
    assign partial_rem = x_reg - (PARTIAL_W'(q_reg) * PARTIAL_W'(DEC_DIV));

    assign bin_hund_prod = 17'(rem_reg) * 17'(HUNDRED);
    assign dec_hund_prod = 18'(rem_reg) * 18'(TENTH_RECIP);

    always_comb begin
        if (!divided_reg) begin
            hund_value = '0;
        end else if (binary_reg) begin
            hund_value = bin_hund_prod[16 -: HUND_W];
        end else begin
            hund_value = dec_hund_prod[TENTH_SHIFT +: HUND_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            divided_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg     <= '0;
                divided_reg <= 1'b0;
            end else if (cmd.bin_shift || cmd.dec_last) begin
                idx_reg     <= idx_reg + 3'd1;
                divided_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg    <= s_byte_count;
            binary_reg <= s_binary_prefix;
        end else if (cmd.bin_shift) begin
            rem_reg <= val_reg[REM_W-1:0] & BIN_REM_MASK;
            val_reg <= {10'b0, val_reg[VALUE_W-1:10]};
        end else if (cmd.dec_start) begin
            prem_reg <= '0;
        end else if (cmd.dec_mul) begin
            x_reg <= partial;
            q_reg <= recip_prod[DEC_SHIFT +: DIGIT_W];
        end else if (cmd.dec_sub) begin
            // The quotient digit shifts in as the dividend digit shifts out.
            val_reg  <= {val_reg[VALUE_W-DIGIT_W-1:0], q_reg};
            prem_reg <= partial_rem[REM_W-1:0];
            if (cmd.dec_last) begin
                rem_reg <= partial_rem[REM_W-1:0];
            end
        end

        if (cmd.out_load) begin
            whole_reg  <= val_reg[WHOLE_W-1:0];
            hund_reg   <= hund_value;
            prefix_reg <= idx_reg;
        end
    end

    assign m_whole_part   = whole_reg;
    assign m_hundredths   = hund_reg;
    assign m_prefix_index = prefix_reg;

    `HRSS_ASSERT_NEXT(a_prem_range, aclk, aresetn, cmd.dec_sub, prem_reg < REM_W'(DEC_DIV))
    `HRSS_ASSERT_SAME(a_idx_range, aclk, aresetn, 1'b1, idx_reg <= MAX_PREFIX)
    `HRSS_ASSERT_NEXT(a_hund_range, aclk, aresetn, cmd.out_load, hund_reg <= MAX_HUND)

endmodule

`default_nettype wire

// ===== hw/rtl/human_readable_size_scaler_core.sv =====
// ----------------------------------------------------------------------------
// Human Readable Size Scaler Core
// Scales a 64-bit byte count by 1024 or 1000 into whole part, hundredths
// and prefix index.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid/s_ready) takes one beat carrying a byte count
// and a flag that picks the binary (1024) or decimal (1000) divisor. The
// result channel (m_valid/m_ready) returns exactly one beat per input beat.
// The value is divided while it exceeds the divisor, at most six times.
// A binary step is a 10-bit shift. A decimal step is a long division by
// 1000 over four 16-bit digits, begun by a check step, each digit a
// reciprocal multiply step followed by a remainder step. A new input beat
// is taken only once the previous result has entered the output register.
// The result sits in an output register, so the core accepts and works on
// the next beat while a result waits. If the receiver stalls, the finished
// item waits until the register frees.
// Reset (aresetn low, synchronous) empties the core and drops m_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module human_readable_size_scaler_core
    import hrss_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [VALUE_W-1:0]   s_byte_count,
    input  wire logic                 s_binary_prefix,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WHOLE_W-1:0]        m_whole_part,
    output logic [HUND_W-1:0]         m_hundredths,
    output logic [PREFIX_W-1:0]       m_prefix_index
);

    hrss_cmd_t    cmd;
    hrss_status_t status;

    hrss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hrss_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_byte_count    (s_byte_count),
        .s_binary_prefix (s_binary_prefix),
        .cmd             (cmd),
        .status          (status),
        .m_whole_part    (m_whole_part),
        .m_hundredths    (m_hundredths),
        .m_prefix_index  (m_prefix_index)
    );

endmodule

`default_nettype wire
